@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the colour ramp RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define S2RGB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define S2RGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/s2rgb_pkg.sv @@
// Shared types and constants of the colour ramp.
package s2rgb_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int DUTY_BITS_DEF   = 8;

	// Position within the ramp: 10 fraction bits, quotient has one more bit.
	localparam int POS_BITS = 10;
	localparam int QUO_BITS = POS_BITS + 1;
	localparam int SEG_BITS = 2;
	localparam int LEVEL_BITS = POS_BITS - SEG_BITS;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LOW = 2'd2;

	// Register reset values.
	localparam int RANGE_LOW_RESET  = 0;
	localparam int RANGE_HIGH_RESET = 4095;
	localparam logic ACTIVE_LOW_RESET = 1'b1;

	// Segment codes.
	localparam logic [SEG_BITS-1:0] SEG_BLUE_CYAN   = 2'd0;
	localparam logic [SEG_BITS-1:0] SEG_CYAN_GREEN  = 2'd1;
	localparam logic [SEG_BITS-1:0] SEG_GREEN_YELLOW = 2'd2;
	localparam logic [SEG_BITS-1:0] SEG_YELLOW_RED  = 2'd3;

	// Control that travels with each transaction down the chain.
	typedef struct packed {
		logic valid;
		logic range_ok;
	} pipe_ctl_t;

endpackage

@@ hw/rtl/s2rgb_ifs.sv @@
// Stream interfaces of the colour ramp: sample in, RGB duty out.
interface s2rgb_sample_if #(
	parameter int SAMPLE_BITS = s2rgb_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface s2rgb_rgb_if #(
	parameter int DUTY_BITS = s2rgb_pkg::DUTY_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] red_duty;
	logic [DUTY_BITS-1:0] green_duty;
	logic [DUTY_BITS-1:0] blue_duty;

	modport source (output valid, output red_duty, output green_duty, output blue_duty,
		input ready);
	modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
		output ready);
endinterface

@@ hw/rtl/s2rgb_clamp.sv @@
// Head cell: clamp the sample and form the offset and span for the divider.
`include "assert_macros.svh"

module s2rgb_clamp #(
	parameter int SAMPLE_BITS = s2rgb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic signed [SAMPLE_BITS-1:0] up_sample,
	input  logic signed [SAMPLE_BITS-1:0] range_low,
	input  logic signed [SAMPLE_BITS-1:0] range_high,
	output s2rgb_pkg::pipe_ctl_t          dn_ctl,
	output logic [SAMPLE_BITS-1:0]        dn_span,
	output logic [SAMPLE_BITS-1:0]        dn_off,
	input  logic                          dn_ready
);

	s2rgb_pkg::pipe_ctl_t          ctl_q;
	logic [SAMPLE_BITS-1:0]        span_q;
	logic [SAMPLE_BITS-1:0]        off_q;
	logic                          ok;
	logic signed [SAMPLE_BITS-1:0] clamped;
	logic [SAMPLE_BITS:0]          span_wide;
	logic [SAMPLE_BITS:0]          off_wide;
	logic                          advance;

	assign advance  = !ctl_q.valid || dn_ready;
	assign up_ready = advance;

	always_comb begin
		ok = range_high > range_low;
		if (up_sample < range_low) begin
			clamped = range_low;
		end else if (up_sample > range_high) begin
			clamped = range_high;
		end else begin
			clamped = up_sample;
		end
		span_wide = {range_high[SAMPLE_BITS-1], range_high} - {range_low[SAMPLE_BITS-1], range_low};
		off_wide  = {clamped[SAMPLE_BITS-1], clamped} - {range_low[SAMPLE_BITS-1], range_low};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q.valid    <= up_valid;
			ctl_q.range_ok <= ok;
		end
	end

	// Empty range: zero span and offset keep the divider quiet.
	always_ff @(posedge clk) begin
		if (advance && up_valid) begin
			span_q <= ok ? span_wide[SAMPLE_BITS-1:0] : '0;
			off_q  <= ok ? off_wide[SAMPLE_BITS-1:0] : '0;
		end
	end

	assign dn_ctl  = ctl_q;
	assign dn_span = span_q;
	assign dn_off  = off_q;

	`S2RGB_ASSERT(a_off_in_span, clk, arst_n, ctl_q.valid |-> (off_q <= span_q), "offset beyond span")
	`S2RGB_ASSERT(a_empty_range_zero, clk, arst_n, (ctl_q.valid && !ctl_q.range_ok) |-> (span_q == '0 && off_q == '0), "empty range not zeroed")
	`S2RGB_ASSERT(a_hold_on_stall, clk, arst_n, (ctl_q.valid && !dn_ready) |=> (ctl_q.valid && $stable(off_q) && $stable(span_q)), "head cell lost a stalled transaction")

endmodule

@@ hw/rtl/s2rgb_div_cell.sv @@
// One restoring-division cell: produce one quotient bit and pass on.
`include "assert_macros.svh"

module s2rgb_div_cell #(
	parameter int SAMPLE_BITS = s2rgb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  s2rgb_pkg::pipe_ctl_t          up_ctl,
	output logic                          up_ready,
	input  logic [SAMPLE_BITS:0]          up_rem,
	input  logic [SAMPLE_BITS-1:0]        up_span,
	input  logic [s2rgb_pkg::QUO_BITS-1:0] up_quo,
	output s2rgb_pkg::pipe_ctl_t          dn_ctl,
	output logic [SAMPLE_BITS:0]          dn_rem,
	output logic [SAMPLE_BITS-1:0]        dn_span,
	output logic [s2rgb_pkg::QUO_BITS-1:0] dn_quo,
	input  logic                          dn_ready
);

	s2rgb_pkg::pipe_ctl_t           ctl_q;
	logic [SAMPLE_BITS:0]           rem_q;
	logic [SAMPLE_BITS-1:0]         span_q;
	logic [s2rgb_pkg::QUO_BITS-1:0] quo_q;
	logic [SAMPLE_BITS+1:0]         diff;
	logic                           take;
	logic [SAMPLE_BITS:0]           rem_next;
	logic                           advance;

	assign advance  = !ctl_q.valid || dn_ready;
	assign up_ready = advance;

	// Remainder stays below twice the span, so after a subtract it fits back.
	always_comb begin
		diff     = {1'b0, up_rem} - {2'b00, up_span};
		take     = !diff[SAMPLE_BITS+1];
		rem_next = take ? diff[SAMPLE_BITS:0] : up_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && up_ctl.valid) begin
			rem_q  <= {rem_next[SAMPLE_BITS-1:0], 1'b0};
			span_q <= up_span;
			quo_q  <= {up_quo[s2rgb_pkg::QUO_BITS-2:0], take};
		end
	end

	assign dn_ctl  = ctl_q;
	assign dn_rem  = rem_q;
	assign dn_span = span_q;
	assign dn_quo  = quo_q;

	`S2RGB_ASSERT(a_rem_bound, clk, arst_n, (ctl_q.valid && ctl_q.range_ok) |-> ({1'b0, rem_q} < {1'b0, span_q, 1'b0}), "remainder out of bound")
	`S2RGB_ASSERT(a_rem_zero_empty, clk, arst_n, (ctl_q.valid && !ctl_q.range_ok) |-> (rem_q == '0), "empty range left a remainder")

endmodule

@@ hw/rtl/s2rgb_colour.sv @@
// Tail cell: map ramp position to RGB, scale to duty width, hold the result.
`include "assert_macros.svh"

module s2rgb_colour #(
	parameter int DUTY_BITS = s2rgb_pkg::DUTY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  s2rgb_pkg::pipe_ctl_t           up_ctl,
	output logic                           up_ready,
	input  logic [s2rgb_pkg::QUO_BITS-1:0] up_quo,
	input  logic                           active_low,
	s2rgb_rgb_if.source                    out_ch
);

	localparam int LB = s2rgb_pkg::LEVEL_BITS;
	localparam int XW = LB + DUTY_BITS;
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
	localparam logic [LB-1:0] LEVEL_FULL = {LB{1'b1}};

	// level * DUTY_MAX / 255: reciprocal estimate, low by at most one, then fix up.
	function automatic logic [DUTY_BITS-1:0] scale_level(input logic [LB-1:0] level);
		logic [XW-1:0]   x;
		logic [XW+1:0]   acc;
		logic [DUTY_BITS-1:0] q;
		logic [XW:0]     rem;
		x   = ({{DUTY_BITS{1'b0}}, level} << DUTY_BITS) - {{DUTY_BITS{1'b0}}, level};
		acc = {2'b00, x} + {2'b00, x >> 8} + {2'b00, x >> 16};
		q   = DUTY_BITS'(acc >> 8);
		rem = {1'b0, x} + (XW+1)'(q) - ((XW+1)'(q) << 8);
		if (rem >= (XW+1)'(LEVEL_FULL)) begin
			q = q + 1'b1;
		end
		return q;
	endfunction

	logic                           valid_q;
	logic [DUTY_BITS-1:0]           red_q;
	logic [DUTY_BITS-1:0]           green_q;
	logic [DUTY_BITS-1:0]           blue_q;
	logic [s2rgb_pkg::POS_BITS-1:0] pos;
	logic [s2rgb_pkg::SEG_BITS-1:0] seg;
	logic [LB-1:0]                  ramp;
	logic [LB-1:0]                  lvl_r;
	logic [LB-1:0]                  lvl_g;
	logic [LB-1:0]                  lvl_b;
	logic [DUTY_BITS-1:0]           duty_r;
	logic [DUTY_BITS-1:0]           duty_g;
	logic [DUTY_BITS-1:0]           duty_b;
	logic                           advance;

	assign advance  = !valid_q || out_ch.ready;
	assign up_ready = advance;

	always_comb begin
		// Saturate the top of the range; an empty range gives position zero.
		if (!up_ctl.range_ok) begin
			pos = '0;
		end else if (up_quo[s2rgb_pkg::QUO_BITS-1]) begin
			pos = '1;
		end else begin
			pos = up_quo[s2rgb_pkg::POS_BITS-1:0];
		end
		seg  = pos[s2rgb_pkg::POS_BITS-1:LB];
		ramp = pos[LB-1:0];
		case (seg)
			s2rgb_pkg::SEG_BLUE_CYAN: begin
				lvl_r = '0; lvl_g = ramp; lvl_b = LEVEL_FULL;
			end
			s2rgb_pkg::SEG_CYAN_GREEN: begin
				lvl_r = '0; lvl_g = LEVEL_FULL; lvl_b = ~ramp;
			end
			s2rgb_pkg::SEG_GREEN_YELLOW: begin
				lvl_r = ramp; lvl_g = LEVEL_FULL; lvl_b = '0;
			end
			default: begin
				lvl_r = LEVEL_FULL; lvl_g = ~ramp; lvl_b = '0;
			end
		endcase
		duty_r = scale_level(lvl_r);
		duty_g = scale_level(lvl_g);
		duty_b = scale_level(lvl_b);
		if (active_low) begin
			duty_r = ~duty_r;
			duty_g = ~duty_g;
			duty_b = ~duty_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && up_ctl.valid) begin
			red_q   <= duty_r;
			green_q <= duty_g;
			blue_q  <= duty_b;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.red_duty   = red_q;
	assign out_ch.green_duty = green_q;
	assign out_ch.blue_duty  = blue_q;

	// Every colour on the ramp has one channel at full and one channel off.
	`S2RGB_ASSERT(a_one_full, clk, arst_n, valid_q |-> (red_q == (active_low ? '0 : DUTY_MAX) || green_q == (active_low ? '0 : DUTY_MAX) || blue_q == (active_low ? '0 : DUTY_MAX)), "no channel at full")
	`S2RGB_ASSERT(a_one_off, clk, arst_n, valid_q |-> (red_q == (active_low ? DUTY_MAX : '0) || blue_q == (active_low ? DUTY_MAX : '0)), "no channel off")

endmodule

@@ hw/rtl/scalar_to_rgb_colour_ramp.sv @@
// Top level of the blue-cyan-green-yellow-red colour ramp.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      sample (signed, SAMPLE_BITS)
//  out_ch   out  valid / ready      red_duty, green_duty, blue_duty (DUTY_BITS each)
//  cfg      in   cfg_write (no ack) cfg_index, cfg_data
//
// One sample enters per cycle while the output does not stall; each sample passes
// through the clamp cell, one division cell per quotient bit and the colour cell.
// The division chain retires one quotient bit per cell.
// Reset clears only the control bits of the cells and loads the register defaults.
// Each cell has its own ready, so a stalled output only backs up the chain as far
// as it is full; bubbles collapse and input is taken while a result waits.
module scalar_to_rgb_colour_ramp #(
	parameter int SAMPLE_BITS = s2rgb_pkg::SAMPLE_BITS_DEF,
	parameter int DUTY_BITS   = s2rgb_pkg::DUTY_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [s2rgb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]               cfg_data,
	s2rgb_sample_if.sink                         in_ch,
	s2rgb_rgb_if.source                          out_ch
);

	localparam int NCELL = s2rgb_pkg::QUO_BITS;

	// Configuration registers; writes to unknown indexes drop.
	logic signed [SAMPLE_BITS-1:0] range_low_q;
	logic signed [SAMPLE_BITS-1:0] range_high_q;
	logic                          active_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= SAMPLE_BITS'(s2rgb_pkg::RANGE_LOW_RESET);
			range_high_q <= SAMPLE_BITS'(s2rgb_pkg::RANGE_HIGH_RESET);
			active_low_q <= s2rgb_pkg::ACTIVE_LOW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				s2rgb_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
				s2rgb_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
				s2rgb_pkg::REG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Chain links: index 0 is the clamp cell output, index NCELL the last divider.
	s2rgb_pkg::pipe_ctl_t           ctl   [NCELL+1];
	logic [SAMPLE_BITS:0]           rem   [NCELL+1];
	logic [SAMPLE_BITS-1:0]         span  [NCELL+1];
	logic [s2rgb_pkg::QUO_BITS-1:0] quo   [NCELL+1];
	logic                           ready [NCELL+1];
	logic [SAMPLE_BITS-1:0]         off0;

	s2rgb_clamp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (in_ch.valid),
		.up_ready  (in_ch.ready),
		.up_sample (in_ch.sample),
		.range_low (range_low_q),
		.range_high(range_high_q),
		.dn_ctl    (ctl[0]),
		.dn_span   (span[0]),
		.dn_off    (off0),
		.dn_ready  (ready[0])
	);

	// Start the remainder at the offset; the quotient fills from the right.
	assign rem[0] = {1'b0, off0};
	assign quo[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_div
		s2rgb_div_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctl  (ctl[i]),
			.up_ready(ready[i]),
			.up_rem  (rem[i]),
			.up_span (span[i]),
			.up_quo  (quo[i]),
			.dn_ctl  (ctl[i+1]),
			.dn_rem  (rem[i+1]),
			.dn_span (span[i+1]),
			.dn_quo  (quo[i+1]),
			.dn_ready(ready[i+1])
		);
	end

	s2rgb_colour #(
		.DUTY_BITS(DUTY_BITS)
	) u_colour (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_ctl    (ctl[NCELL]),
		.up_ready  (ready[NCELL]),
		.up_quo    (quo[NCELL]),
		.active_low(active_low_q),
		.out_ch    (out_ch)
	);

endmodule
